>>> design/iprc_pkg.sv
// ----------------------------------------------------------------------------
// iprc_pkg
// types and constants of the icmp probe reply classifier
// ----------------------------------------------------------------------------
package iprc_pkg;

    typedef enum logic [1:0] {
        VERDICT_OTHER   = 2'd0,
        VERDICT_HOP     = 2'd1,
        VERDICT_ECHO    = 2'd2,
        VERDICT_UNREACH = 2'd3
    } verdict_t;

    typedef enum logic [1:0] {
        CFG_IPV6_MODE   = 2'd0,
        CFG_PROBE_IDENT = 2'd1,
        CFG_PROBE_SEQ   = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_t;

    typedef struct packed {
        verdict_t   verdict;
        logic [7:0] error_code;
    } out_t;

    localparam logic [7:0] V4_ECHO_REPLY       = 8'd0;
    localparam logic [7:0] V4_DEST_UNREACH     = 8'd3;
    localparam logic [7:0] V4_ECHO_REQUEST     = 8'd8;
    localparam logic [7:0] V4_TIME_EXCEEDED    = 8'd11;
    localparam logic [7:0] V6_DEST_UNREACH     = 8'd1;
    localparam logic [7:0] V6_TIME_EXCEEDED    = 8'd3;
    localparam logic [7:0] V6_ECHO_REQUEST     = 8'd128;
    localparam logic [7:0] V6_ECHO_REPLY       = 8'd129;
    localparam logic [7:0] PROTO_ICMP          = 8'd1;
    localparam logic [7:0] NEXT_HDR_ICMP6      = 8'd58;
    localparam logic [3:0] IP_VERSION4         = 4'd4;
    localparam logic [5:0] IPV6_HDR_LEN        = 6'd40;
    localparam logic [5:0] MIN_IPV4_HDR_LEN    = 6'd20;

endpackage

>>> design/icmp_probe_reply_classifier.sv
// the verdict is registered into the output register as the final byte is accepted
// throughput: one byte per cycle while the result side takes verdicts
// the only stall is a verdict waiting in the output register
// reset: synchronous active low aresetn, registers but m_data_reg to their defaults, parser cleared
// ----------------------------------------------------------------------------
// icmp_probe_reply_classifier
// classifies a received datagram as hop, echo reply, unreachable or other
// ----------------------------------------------------------------------------
module icmp_probe_reply_classifier
    import iprc_pkg::*;
#(
    parameter int MAX_DATAGRAM = 2048
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_t         s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_t        m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int PW = $clog2(MAX_DATAGRAM + 1);

    logic            ipv6_mode_reg;
    logic [15:0]     probe_ident_reg;
    logic [15:0]     probe_seq_reg;

    logic [PW-1:0]   pos_reg,   pos_next;
    logic [5:0]      ohl_reg,   ohl_next;
    logic            ohl_ok_reg, ohl_ok_next;
    logic [7:0]      type_reg,  type_next;
    logic [7:0]      code_reg,  code_next;
    logic [5:0]      qhl_reg,   qhl_next;
    logic [7:0]      qproto_reg, qproto_next;
    logic            reply_match_reg, reply_match_next;
    logic            quoted_match_reg, quoted_match_next;

    logic            m_valid_reg;
    out_t            m_data_reg;
    out_t            result;

    logic            s_fire;
    logic [7:0]      b;
    logic            active;
    logic [PW-1:0]   rel;
    logic [PW-1:0]   qoff;
    logic [PW-1:0]   len;
    logic [PW-1:0]   msg_len;
    logic [PW-1:0]   ohl_ext;
    logic [PW-1:0]   qhl_ext;
    logic            len_ok;
    logic [7:0]      reply_t;
    logic [7:0]      exceed_t;
    logic [7:0]      unreach_t;

    function automatic logic field_match(input logic [1:0]  idx,
                                         input logic [7:0]  val,
                                         input logic [15:0] ident,
                                         input logic [15:0] seq);
        logic m;
        unique case (idx)
            2'd0:    m = (val == ident[15:8]);
            2'd1:    m = (val == ident[7:0]);
            2'd2:    m = (val == seq[15:8]);
            default: m = (val == seq[7:0]);
        endcase
        return m;
    endfunction

    assign s_ready   = !m_valid_reg || m_ready;
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign b         = s_data.data_byte;

    // per-byte parser update
    always_comb begin
        pos_next          = pos_reg;
        ohl_next          = ohl_reg;
        ohl_ok_next       = ohl_ok_reg;
        type_next         = type_reg;
        code_next         = code_reg;
        qhl_next          = qhl_reg;
        qproto_next       = qproto_reg;
        reply_match_next  = reply_match_reg;
        quoted_match_next = quoted_match_reg;
        active            = 1'b0;
        rel               = '0;
        qoff              = '0;
        if (pos_reg < PW'(MAX_DATAGRAM)) begin
            pos_next = pos_reg + PW'(1);
            if (pos_reg == '0) begin
                ohl_next    = {b[3:0], 2'b00};
                ohl_ok_next = (b[7:4] == IP_VERSION4) && ({b[3:0], 2'b00} >= MIN_IPV4_HDR_LEN);
            end
            if (ipv6_mode_reg) begin
                active = 1'b1;
                rel    = pos_reg;
            end else if (ohl_ok_next && pos_reg >= PW'(ohl_next)) begin
                active = 1'b1;
                rel    = pos_reg - PW'(ohl_next);
            end
            if (active) begin
                if (rel == PW'(0)) begin
                    type_next = b;
                end else if (rel == PW'(1)) begin
                    code_next = b;
                end else if (rel >= PW'(4) && rel <= PW'(7)) begin
                    if (!field_match(rel[1:0], b, probe_ident_reg, probe_seq_reg))
                        reply_match_next = 1'b0;
                end else if (rel == PW'(8)) begin
                    qhl_next = ipv6_mode_reg ? IPV6_HDR_LEN : {b[3:0], 2'b00};
                end
                if ((ipv6_mode_reg && rel == PW'(14)) || (!ipv6_mode_reg && rel == PW'(17)))
                    qproto_next = b;
                if (rel > PW'(8) && qhl_reg >= MIN_IPV4_HDR_LEN
                        && rel >= PW'(8) + PW'(qhl_reg)) begin
                    qoff = rel - PW'(8) - PW'(qhl_reg);
                    if (qoff == PW'(0)) begin
                        if (b != (ipv6_mode_reg ? V6_ECHO_REQUEST : V4_ECHO_REQUEST))
                            quoted_match_next = 1'b0;
                    end else if (qoff >= PW'(4) && qoff <= PW'(7)) begin
                        if (!field_match(qoff[1:0], b, probe_ident_reg, probe_seq_reg))
                            quoted_match_next = 1'b0;
                    end
                end
            end
        end
    end

    // verdict on the final byte
    always_comb begin
        reply_t    = ipv6_mode_reg ? V6_ECHO_REPLY    : V4_ECHO_REPLY;
        exceed_t   = ipv6_mode_reg ? V6_TIME_EXCEEDED : V4_TIME_EXCEEDED;
        unreach_t  = ipv6_mode_reg ? V6_DEST_UNREACH  : V4_DEST_UNREACH;
        len        = pos_next;
        ohl_ext    = PW'(ohl_next);
        qhl_ext    = PW'(qhl_next);
        result.verdict    = VERDICT_OTHER;
        result.error_code = 8'd0;
        if (ipv6_mode_reg) begin
            len_ok  = 1'b1;
            msg_len = len;
        end else begin
            len_ok  = (len >= PW'(20)) && ohl_ok_next && (ohl_ext + PW'(8) <= len);
            msg_len = len - ohl_ext;
        end
        if (len_ok && msg_len >= PW'(8)) begin
            if (type_next == reply_t) begin
                if (reply_match_next)
                    result.verdict = VERDICT_ECHO;
            end else if (type_next == exceed_t || type_next == unreach_t) begin
                if (msg_len >= (ipv6_mode_reg ? PW'(48) : PW'(28))
                        && qhl_next >= MIN_IPV4_HDR_LEN
                        && PW'(16) + qhl_ext <= msg_len
                        && qproto_next == (ipv6_mode_reg ? NEXT_HDR_ICMP6 : PROTO_ICMP)
                        && quoted_match_next) begin
                    result.error_code = code_next;
                    result.verdict    = (type_next == exceed_t) ? VERDICT_HOP
                                                                : VERDICT_UNREACH;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ipv6_mode_reg    <= 1'b0;
            probe_ident_reg  <= 16'd1;
            probe_seq_reg    <= 16'd0;
            pos_reg          <= '0;
            ohl_reg          <= '0;
            ohl_ok_reg       <= 1'b0;
            type_reg         <= '0;
            code_reg         <= '0;
            qhl_reg          <= '0;
            qproto_reg       <= '0;
            reply_match_reg  <= 1'b1;
            quoted_match_reg <= 1'b1;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_IPV6_MODE:   ipv6_mode_reg   <= cfg_data[0];
                    CFG_PROBE_IDENT: probe_ident_reg <= cfg_data;
                    CFG_PROBE_SEQ:   probe_seq_reg   <= cfg_data;
                    default: begin
                    end
                endcase
            end
            if (m_valid_reg && m_ready)
                m_valid_reg <= 1'b0;
            if (s_fire) begin
                if (s_data.last_byte) begin
                    m_valid_reg      <= 1'b1;
                    m_data_reg       <= result;
                    pos_reg          <= '0;
                    ohl_reg          <= '0;
                    ohl_ok_reg       <= 1'b0;
                    type_reg         <= '0;
                    code_reg         <= '0;
                    qhl_reg          <= '0;
                    qproto_reg       <= '0;
                    reply_match_reg  <= 1'b1;
                    quoted_match_reg <= 1'b1;
                end else begin
                    pos_reg          <= pos_next;
                    ohl_reg          <= ohl_next;
                    ohl_ok_reg       <= ohl_ok_next;
                    type_reg         <= type_next;
                    code_reg         <= code_next;
                    qhl_reg          <= qhl_next;
                    qproto_reg       <= qproto_next;
                    reply_match_reg  <= reply_match_next;
                    quoted_match_reg <= quoted_match_next;
                end
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_final_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_data.last_byte |=> m_valid)
        else $error("final byte gave no verdict");

    a_final_clears_parser: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_data.last_byte |=> pos_reg == '0 && reply_match_reg && quoted_match_reg)
        else $error("parser not cleared after final byte");

    a_code_only_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.verdict == VERDICT_OTHER || m_data.verdict == VERDICT_ECHO)
        |-> m_data.error_code == 8'd0)
        else $error("error code reported without a matched error message");

    a_position_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && !s_data.last_byte && pos_reg < PW'(MAX_DATAGRAM)
        |=> pos_reg == $past(pos_reg) + PW'(1))
        else $error("byte position did not advance");
`endif

endmodule

>>> dv/icmp_probe_reply_classifier_tb.sv
// ----------------------------------------------------------------------------
// icmp_probe_reply_classifier_tb
// self-checking bench: datagrams built from probe templates go in one byte per
// transaction, a byte-level parser model predicts untyped verdicts, and the
// result channel is compared in order, with random gaps and receiver hold-off
// ----------------------------------------------------------------------------
module icmp_probe_reply_classifier_tb;
    import iprc_pkg::*;

    localparam int MAX_DATAGRAM      = 2048;
    localparam int RAND_ITEMS        = 200;
    localparam int TAIL_CYCLES       = 4;
    localparam int HOLD_CYCLES       = 400;
    localparam int MIN_ICMP_LEN      = 8;
    localparam int MIN_ICMP4_ERR_LEN = 28;
    localparam int MIN_ICMP6_ERR_LEN = 48;
    localparam int QUOTE_PROTO_OFS4  = 9;
    localparam int QUOTE_PROTO_OFS6  = 6;
    localparam logic [3:0] IP_VERSION6 = 4'd6;
    localparam logic [7:0] PROTO_UDP   = 8'd17;

    typedef enum {
        PK_NOISE, PK_REPLY, PK_EXCEED, PK_UNREACH, PK_ECHO_REQ, PK_BADVER, PK_BADPROTO
    } pkt_kind_t;

    typedef struct {
        pkt_kind_t  kind;
        logic       fmt_v6;
        logic       id_ok;
        logic [7:0] code;
        int         ihl;
        int         qihl;
        int         pad;
        int         trunc;
    } pkt_spec_t;

    typedef struct {
        logic      mode_v6;
        pkt_spec_t spec;
        logic      typed;
        out_t      res;
    } dir_row_t;

    localparam int N_DIR = 24;

    // typed result only where obvious, the rest goes through the parser model
    dir_row_t dir_table [0:N_DIR-1] = '{
        '{1'b0, '{PK_NOISE,    1'b0, 1'b1, 8'h00,  5,  5,    0,  0}, 1'b1, '{VERDICT_OTHER,   8'h00}},
        '{1'b0, '{PK_REPLY,    1'b0, 1'b1, 8'h00,  5,  5,    0,  0}, 1'b1, '{VERDICT_ECHO,    8'h00}},
        '{1'b0, '{PK_REPLY,    1'b0, 1'b0, 8'h00,  5,  5,    0,  0}, 1'b1, '{VERDICT_OTHER,   8'h00}},
        '{1'b0, '{PK_EXCEED,   1'b0, 1'b1, 8'h00,  5,  5,    0,  0}, 1'b1, '{VERDICT_HOP,     8'h00}},
        '{1'b0, '{PK_EXCEED,   1'b0, 1'b1, 8'hff,  5,  5,    0,  0}, 1'b1, '{VERDICT_HOP,     8'hff}},
        '{1'b0, '{PK_UNREACH,  1'b0, 1'b1, 8'h03,  5,  5,    0,  0}, 1'b1, '{VERDICT_UNREACH, 8'h03}},
        '{1'b0, '{PK_UNREACH,  1'b0, 1'b0, 8'h01,  5,  5,    0,  0}, 1'b1, '{VERDICT_OTHER,   8'h00}},
        '{1'b0, '{PK_ECHO_REQ, 1'b0, 1'b1, 8'h00,  5,  5,    0,  0}, 1'b1, '{VERDICT_OTHER,   8'h00}},
        '{1'b0, '{PK_BADVER,   1'b0, 1'b1, 8'h00,  5,  5,    0,  0}, 1'b1, '{VERDICT_OTHER,   8'h00}},
        '{1'b0, '{PK_EXCEED,   1'b0, 1'b1, 8'h00,  4,  5,    0,  0}, 1'b1, '{VERDICT_OTHER,   8'h00}},
        '{1'b0, '{PK_EXCEED,   1'b0, 1'b1, 8'h00,  5,  4,    0,  0}, 1'b1, '{VERDICT_OTHER,   8'h00}},
        '{1'b0, '{PK_BADPROTO, 1'b0, 1'b1, 8'h00,  5,  5,    0,  0}, 1'b1, '{VERDICT_OTHER,   8'h00}},
        '{1'b0, '{PK_EXCEED,   1'b0, 1'b1, 8'h00,  5,  5,    0, 40}, 1'b1, '{VERDICT_OTHER,   8'h00}},
        '{1'b0, '{PK_EXCEED,   1'b0, 1'b1, 8'h5a, 15, 15,    3,  0}, 1'b0, '{VERDICT_OTHER,   8'h00}},
        '{1'b0, '{PK_REPLY,    1'b0, 1'b1, 8'h00,  5,  5,    4,  0}, 1'b0, '{VERDICT_OTHER,   8'h00}},
        '{1'b0, '{PK_UNREACH,  1'b0, 1'b1, 8'h80,  5,  5,    6,  0}, 1'b0, '{VERDICT_OTHER,   8'h00}},
        '{1'b1, '{PK_REPLY,    1'b1, 1'b1, 8'h00,  5,  5,    0,  0}, 1'b1, '{VERDICT_ECHO,    8'h00}},
        '{1'b1, '{PK_EXCEED,   1'b1, 1'b1, 8'h00,  5,  5,    0,  0}, 1'b1, '{VERDICT_HOP,     8'h00}},
        '{1'b1, '{PK_UNREACH,  1'b1, 1'b1, 8'h04,  5,  5,    0,  0}, 1'b1, '{VERDICT_UNREACH, 8'h04}},
        '{1'b1, '{PK_BADPROTO, 1'b1, 1'b1, 8'h00,  5,  5,    0,  0}, 1'b1, '{VERDICT_OTHER,   8'h00}},
        '{1'b1, '{PK_REPLY,    1'b0, 1'b1, 8'h00,  5,  5,    0,  0}, 1'b0, '{VERDICT_OTHER,   8'h00}},
        '{1'b1, '{PK_NOISE,    1'b1, 1'b1, 8'h00,  5,  5,    7,  0}, 1'b1, '{VERDICT_OTHER,   8'h00}},
        '{1'b1, '{PK_EXCEED,   1'b1, 1'b1, 8'h00,  5,  5,    0, 47}, 1'b1, '{VERDICT_OTHER,   8'h00}},
        '{1'b1, '{PK_EXCEED,   1'b1, 1'b1, 8'h21,  5,  5,    5,  0}, 1'b0, '{VERDICT_OTHER,   8'h00}}
    };

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    in_t         s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    out_t        m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    // register copy
    logic        cfg_v6    = 1'b0;
    logic [15:0] cfg_ident = 16'h0001;
    logic [15:0] cfg_seq   = 16'h0000;

    // parser model state
    logic [11:0] pos      = '0;
    logic [5:0]  ohl      = '0;
    logic        ohl_ok   = 1'b0;
    logic [7:0]  msg_type = '0;
    logic [7:0]  msg_code = '0;
    logic [5:0]  qhl      = '0;
    logic [7:0]  qproto   = '0;
    logic        reply_ok = 1'b1;
    logic        quote_ok = 1'b1;

    out_t       pending_verdicts[$];
    logic [7:0] pkt[$];
    int         max_gap   = 3;
    int         max_stall = 3;
    int         hold_req  = 0;
    int         errors    = 0;

    icmp_probe_reply_classifier #(
        .MAX_DATAGRAM(MAX_DATAGRAM)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #6 aclk = ~aclk;

    function automatic void clear_parser();
        pos      = '0;
        ohl      = '0;
        ohl_ok   = 1'b0;
        msg_type = '0;
        msg_code = '0;
        qhl      = '0;
        qproto   = '0;
        reply_ok = 1'b1;
        quote_ok = 1'b1;
    endfunction

    function automatic logic probe_byte_ok(int idx, logic [7:0] b);
        logic [31:0] w;
        w = {cfg_ident, cfg_seq};
        return b == w[31 - 8 * idx -: 8];
    endfunction

    function automatic void parse_byte(int p, logic [7:0] b);
        int rel;
        int o;
        if (p == 0) begin
            ohl    = {b[3:0], 2'b00};
            ohl_ok = (b[7:4] == IP_VERSION4) && (ohl >= MIN_IPV4_HDR_LEN);
        end
        if (cfg_v6) begin
            rel = p;
        end else begin
            if (!ohl_ok || p < int'(ohl)) return;
            rel = p - int'(ohl);
        end
        if (rel == 0) begin
            msg_type = b;
        end else if (rel == 1) begin
            msg_code = b;
        end else if (rel >= 4 && rel <= 7) begin
            if (!probe_byte_ok(rel - 4, b)) reply_ok = 1'b0;
        end else if (rel == 8) begin
            qhl = cfg_v6 ? IPV6_HDR_LEN : {b[3:0], 2'b00};
        end
        if ((cfg_v6 && rel == 14) || (!cfg_v6 && rel == 17)) qproto = b;
        if (rel > 8 && qhl >= MIN_IPV4_HDR_LEN && rel >= 8 + int'(qhl)) begin
            o = rel - 8 - int'(qhl);
            if (o == 0) begin
                if (b != (cfg_v6 ? V6_ECHO_REQUEST : V4_ECHO_REQUEST)) quote_ok = 1'b0;
            end else if (o >= 4 && o <= 7) begin
                if (!probe_byte_ok(o - 4, b)) quote_ok = 1'b0;
            end
        end
    endfunction

    function automatic out_t decide_verdict(int len);
        out_t       r;
        int         msg_len;
        logic [7:0] t_reply;
        logic [7:0] t_exceed;
        logic [7:0] t_unreach;
        r         = '{VERDICT_OTHER, 8'h00};
        t_reply   = cfg_v6 ? V6_ECHO_REPLY : V4_ECHO_REPLY;
        t_exceed  = cfg_v6 ? V6_TIME_EXCEEDED : V4_TIME_EXCEEDED;
        t_unreach = cfg_v6 ? V6_DEST_UNREACH : V4_DEST_UNREACH;
        if (cfg_v6) begin
            msg_len = len;
        end else begin
            if (len < int'(MIN_IPV4_HDR_LEN) || !ohl_ok || int'(ohl) + MIN_ICMP_LEN > len)
                return r;
            msg_len = len - int'(ohl);
        end
        if (msg_len < MIN_ICMP_LEN) return r;
        if (msg_type == t_reply) begin
            if (reply_ok) r.verdict = VERDICT_ECHO;
            return r;
        end
        if (msg_type == t_exceed || msg_type == t_unreach) begin
            if (msg_len < (cfg_v6 ? MIN_ICMP6_ERR_LEN : MIN_ICMP4_ERR_LEN)
                    || qhl < MIN_IPV4_HDR_LEN
                    || 2 * MIN_ICMP_LEN + int'(qhl) > msg_len
                    || qproto != (cfg_v6 ? NEXT_HDR_ICMP6 : PROTO_ICMP)
                    || !quote_ok)
                return r;
            r.error_code = msg_code;
            r.verdict    = (msg_type == t_exceed) ? VERDICT_HOP : VERDICT_UNREACH;
        end
        return r;
    endfunction

    function automatic logic classify_byte(logic [7:0] b, logic last, output out_t r);
        if (pos < MAX_DATAGRAM) begin
            parse_byte(int'(pos), b);
            pos = pos + 1'b1;
        end
        if (!last) return 1'b0;
        r = decide_verdict(int'(pos));
        clear_parser();
        return 1'b1;
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void push_probe_id(logic [31:0] id_word);
        for (int i = 3; i >= 0; i--) pkt.push_back(id_word[8 * i +: 8]);
    endfunction

    function automatic void build_pkt(pkt_spec_t sp);
        logic [31:0] id_word;
        logic [7:0]  msg;
        int          flip;
        int          qlen;
        int          qbase;
        int          pofs;
        pkt.delete();
        id_word = {cfg_ident, cfg_seq};
        if (!sp.id_ok) begin
            flip = $urandom_range(0, 3);
            id_word[8 * flip +: 8] = id_word[8 * flip +: 8] ^ 8'($urandom_range(1, 255));
        end
        if (sp.kind == PK_NOISE) begin
            repeat ((sp.pad > 0) ? sp.pad : 1) pkt.push_back(rand_byte());
            return;
        end
        if (!sp.fmt_v6) begin
            pkt.push_back({(sp.kind == PK_BADVER) ? IP_VERSION6 : IP_VERSION4, 4'(sp.ihl)});
            for (int i = 1; i < 4 * sp.ihl; i++) pkt.push_back(rand_byte());
        end
        case (sp.kind)
            PK_REPLY:    msg = sp.fmt_v6 ? V6_ECHO_REPLY : V4_ECHO_REPLY;
            PK_UNREACH:  msg = sp.fmt_v6 ? V6_DEST_UNREACH : V4_DEST_UNREACH;
            PK_ECHO_REQ: msg = sp.fmt_v6 ? V6_ECHO_REQUEST : V4_ECHO_REQUEST;
            default:     msg = sp.fmt_v6 ? V6_TIME_EXCEEDED : V4_TIME_EXCEEDED;
        endcase
        pkt.push_back(msg);
        pkt.push_back(sp.code);
        repeat (2) pkt.push_back(rand_byte());
        if (sp.kind == PK_REPLY || sp.kind == PK_ECHO_REQ) begin
            push_probe_id(id_word);
        end else begin
            repeat (4) pkt.push_back(rand_byte());
            qlen  = sp.fmt_v6 ? int'(IPV6_HDR_LEN) : ((sp.qihl > 0) ? 4 * sp.qihl : 1);
            qbase = pkt.size();
            repeat (qlen) pkt.push_back(rand_byte());
            if (!sp.fmt_v6) pkt[qbase] = {IP_VERSION4, 4'(sp.qihl)};
            pofs = sp.fmt_v6 ? QUOTE_PROTO_OFS6 : QUOTE_PROTO_OFS4;
            if (pofs < qlen) begin
                if (sp.kind == PK_BADPROTO) pkt[qbase + pofs] = PROTO_UDP;
                else pkt[qbase + pofs] = sp.fmt_v6 ? NEXT_HDR_ICMP6 : PROTO_ICMP;
            end
            pkt.push_back(sp.fmt_v6 ? V6_ECHO_REQUEST : V4_ECHO_REQUEST);
            repeat (3) pkt.push_back(rand_byte());
            push_probe_id(id_word);
        end
        repeat (sp.pad) pkt.push_back(rand_byte());
        if (sp.trunc > 0) begin
            while (pkt.size() > sp.trunc) void'(pkt.pop_back());
        end
    endfunction

    function automatic pkt_spec_t random_spec();
        pkt_spec_t sp;
        int        pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)      sp.kind = PK_REPLY;
        else if (pick < 55) sp.kind = PK_EXCEED;
        else if (pick < 75) sp.kind = PK_UNREACH;
        else if (pick < 80) sp.kind = PK_ECHO_REQ;
        else if (pick < 83) sp.kind = PK_BADVER;
        else if (pick < 86) sp.kind = PK_BADPROTO;
        else                sp.kind = PK_NOISE;
        sp.fmt_v6 = ($urandom_range(0, 9) == 0) ? !cfg_v6 : cfg_v6;
        sp.id_ok  = ($urandom_range(0, 3) != 0);
        sp.code   = rand_byte();
        sp.ihl    = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : 5;
        sp.qihl   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : 5;
        sp.pad    = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 6);
        sp.trunc  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 70) : 0;
        return sp;
    endfunction

    task automatic send_pkt(input logic typed = 1'b0,
                            input out_t typed_res = '{VERDICT_OTHER, 8'h00});
        int   gap;
        logic last;
        logic has_res;
        out_t pred;
        for (int i = 0; i < pkt.size(); i++) begin
            gap  = $urandom_range(0, max_gap);
            last = (i == pkt.size() - 1);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_valid <= 1'b1;
            s_data  <= in_t'{data_byte: pkt[i], last_byte: last};
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);
            has_res = classify_byte(pkt[i], last, pred);
            if (has_res) pending_verdicts.push_back(typed ? typed_res : pred);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic configure(input logic v6, input logic [15:0] ident, input logic [15:0] seq);
        cfg_index_t  regs [3];
        logic [15:0] vals [3];
        regs = '{CFG_IPV6_MODE, CFG_PROBE_IDENT, CFG_PROBE_SEQ};
        vals = '{{15'd0, v6}, ident, seq};
        for (int k = 0; k < 3; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[k];
            cfg_data  <= vals[k];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
        end
        cfg_valid <= 1'b0;
        cfg_v6    = v6;
        cfg_ident = ident;
        cfg_seq   = seq;
    endtask

    // verdict check
    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t: unexpected verdict %0d code %0d", $time,
                         m_data.verdict, m_data.error_code);
                errors++;
            end else begin
                want = pending_verdicts.pop_front();
                if (m_data.verdict !== want.verdict) begin
                    $display("%0t: verdict expected %0d actual %0d", $time,
                             want.verdict, m_data.verdict);
                    errors++;
                end
                if (m_data.error_code !== want.error_code) begin
                    $display("%0t: error_code expected %0d actual %0d", $time,
                             want.error_code, m_data.error_code);
                    errors++;
                end
            end
        end
    end

    // result side ready
    initial begin
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_req != 0) begin
                m_ready <= 1'b0;
                repeat (hold_req) @(posedge aclk);
                hold_req = 0;
            end
            stall = $urandom_range(0, max_stall);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    initial begin
        #3_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        pkt_spec_t   sp;
        int          rand_items;
        int          left_in_phase;
        int          phase;
        int          flip;
        logic        v6;
        logic [15:0] ident;
        logic [15:0] seq;
        rand_items    = 0;
        left_in_phase = 0;
        phase         = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < N_DIR; r++) begin
            if (dir_table[r].mode_v6 != cfg_v6) begin
                drain();
                configure(dir_table[r].mode_v6, cfg_ident, cfg_seq);
            end
            build_pkt(dir_table[r].spec);
            send_pkt(dir_table[r].typed, dir_table[r].res);
        end

        // receiver holds off while short datagrams keep coming
        drain();
        configure(1'b0, 16'h0000, 16'h0000);
        hold_req = HOLD_CYCLES;
        repeat (12) begin
            sp      = random_spec();
            sp.kind = PK_NOISE;
            sp.pad  = $urandom_range(1, 3);
            build_pkt(sp);
            send_pkt();
        end

        while (rand_items < RAND_ITEMS) begin
            if (left_in_phase == 0) begin
                drain();
                case (phase)
                    0: begin v6 = 1'b0; ident = 16'h0000; seq = 16'h0000; end
                    1: begin v6 = 1'b1; ident = 16'hffff; seq = 16'hffff; end
                    2: begin v6 = 1'b0; ident = 16'hffff; seq = 16'h0000; end
                    3: begin v6 = 1'b1; ident = 16'h0000; seq = 16'hffff; end
                    default: begin
                        v6    = 1'($urandom_range(0, 1));
                        ident = 16'($urandom_range(0, 65535));
                        seq   = 16'($urandom_range(0, 65535));
                    end
                endcase
                configure(v6, ident, seq);
                max_gap       = (phase % 4 == 2) ? 0 : 3;
                max_stall     = (phase % 4 == 2) ? 0 : 3;
                left_in_phase = 2;
                phase++;
            end
            sp = random_spec();
            build_pkt(sp);
            if ($urandom_range(0, 9) == 0) begin
                flip      = $urandom_range(0, pkt.size() - 1);
                pkt[flip] = pkt[flip] ^ 8'($urandom_range(1, 255));
            end
            rand_items += pkt.size();
            left_in_phase--;
            send_pkt();
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
